// File: hdl/lpht_pkg.sv
// Shared constants, codes and control types for the linear-probing hash table.
package lpht_pkg;

  // Table geometry. The slot count is a power of two, so the home slot is the low key bits.
  localparam int unsigned SLOT_BITS  = 4;
  localparam int unsigned CAPACITY   = 1 << SLOT_BITS;
  localparam int unsigned VALUE_BITS = 32;

  // Field widths of the transfers.
  localparam int unsigned KEY_W      = 31;
  localparam int unsigned DATA_W     = 32;
  localparam int unsigned SLOT_OUT_W = 4;

  typedef enum logic [1:0] {
    CMD_INSERT = 2'd0,
    CMD_LOOKUP = 2'd1,
    CMD_UPDATE = 2'd2,
    CMD_DELETE = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    ST_DONE      = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_FULL      = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    MARK_EMPTY = 2'd0,
    MARK_USED  = 2'd1,
    MARK_GRAVE = 2'd2
  } mark_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;    // capture a request and start at its home slot
    logic step;    // move the probe to the next slot
    logic commit;  // apply the outcome and load the result register
  } ctrl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic done;    // the current probe ends the search
  } dp_stat_t;

endpackage

// File: hdl/lpht_if.sv
// Request and response channel interfaces of the hash table.
interface lpht_req_if;
  import lpht_pkg::*;
  logic                    valid;
  logic                    ready;
  cmd_e                    command;
  logic [KEY_W-1:0]        record_key;
  logic [DATA_W-1:0]       record_value;

  modport source (output valid, command, record_key, record_value, input ready);
  modport sink   (input valid, command, record_key, record_value, output ready);
endinterface

interface lpht_rsp_if;
  import lpht_pkg::*;
  logic                    valid;
  logic                    ready;
  status_e                 status;
  logic [SLOT_OUT_W-1:0]   slot_index;
  logic [DATA_W-1:0]       read_value;

  modport source (output valid, status, slot_index, read_value, input ready);
  modport sink   (input valid, status, slot_index, read_value, output ready);
endinterface

// File: hdl/lpht_dp.sv
// Datapath: slot marks, key and value stores, probe pointer and result register.
module lpht_dp import lpht_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  ctrl_cmd_t             cmd_i,
  output dp_stat_t              stat_o,
  input  cmd_e                  command_i,
  input  logic [KEY_W-1:0]      record_key_i,
  input  logic [DATA_W-1:0]     record_value_i,
  output status_e               status_o,
  output logic [SLOT_OUT_W-1:0] slot_index_o,
  output logic [DATA_W-1:0]     read_value_o
);

  localparam logic [SLOT_BITS-1:0] CntLast = SLOT_BITS'(CAPACITY - 1);

  mark_e                 mark_q [CAPACITY];
  logic [KEY_W-1:0]      key_mem [CAPACITY];
  logic [VALUE_BITS-1:0] val_mem [CAPACITY];

  cmd_e                  op_q;
  logic [KEY_W-1:0]      key_q;
  logic [VALUE_BITS-1:0] val_q;
  logic [SLOT_BITS-1:0]  idx_q, idx_d;
  logic [SLOT_BITS-1:0]  cnt_q, cnt_d;
  logic [KEY_W-1:0]      key_rd_q;
  logic [VALUE_BITS-1:0] val_rd_q;

  status_e               status_q, status_d;
  logic [SLOT_OUT_W-1:0] slot_q, slot_d;
  logic [DATA_W-1:0]     rd_q, rd_d;

  mark_e mark_cur;
  logic  is_insert, key_hit, is_free, is_last, success;

  always_comb begin
    mark_cur  = mark_q[idx_q];
    is_insert = (op_q == CMD_INSERT);
    is_free   = (mark_cur != MARK_USED);
    key_hit   = (mark_cur == MARK_USED) && (key_rd_q == key_q);
    is_last   = (cnt_q == CntLast);
    if (is_insert) begin
      stat_o.done = is_free || is_last;
      success     = is_free;
    end else begin
      stat_o.done = (mark_cur == MARK_EMPTY) || key_hit || is_last;
      success     = key_hit;
    end
  end

  // Probe pointer: starts at the home slot and wraps through the table.
  always_comb begin
    idx_d = idx_q;
    cnt_d = cnt_q;
    if (cmd_i.load) begin
      idx_d = record_key_i[SLOT_BITS-1:0];
      cnt_d = '0;
    end else if (cmd_i.step) begin
      idx_d = idx_q + SLOT_BITS'(1);
      cnt_d = cnt_q + SLOT_BITS'(1);
    end
  end

  always_comb begin
    status_d = status_q;
    slot_d   = slot_q;
    rd_d     = rd_q;
    if (cmd_i.commit) begin
      if (success) begin
        status_d = ST_DONE;
        slot_d   = SLOT_OUT_W'(idx_q);
        rd_d     = (op_q == CMD_LOOKUP) ? DATA_W'(val_rd_q) : '0;
      end else begin
        status_d = is_insert ? ST_FULL : ST_NOT_FOUND;
        slot_d   = '0;
        rd_d     = '0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q  <= command_i;
      key_q <= record_key_i;
      val_q <= VALUE_BITS'(record_value_i);
    end
    idx_q    <= idx_d;
    cnt_q    <= cnt_d;
    status_q <= status_d;
    slot_q   <= slot_d;
    rd_q     <= rd_d;
  end

  // Store reads follow the next probe pointer, so the words of the slot under
  // test are registered by the time it is examined. Writes happen only at the
  // end of an item, and the next item reads again when it is loaded.
  always_ff @(posedge clk_i) begin
    key_rd_q <= key_mem[idx_d];
    val_rd_q <= val_mem[idx_d];
  end

  // Key and value stores: written only when a command succeeds.
  always_ff @(posedge clk_i) begin
    if (cmd_i.commit && success) begin
      if (is_insert) begin
        key_mem[idx_q] <= key_q;
      end
      if (is_insert || (op_q == CMD_UPDATE)) begin
        val_mem[idx_q] <= val_q;
      end
    end
  end

  // Slot marks are cleared to empty by reset.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < CAPACITY; i++) begin
        mark_q[i] <= MARK_EMPTY;
      end
    end else if (cmd_i.commit && success) begin
      if (is_insert) begin
        mark_q[idx_q] <= MARK_USED;
      end else if (op_q == CMD_DELETE) begin
        mark_q[idx_q] <= MARK_GRAVE;
      end
    end
  end

  assign status_o     = status_q;
  assign slot_index_o = slot_q;
  assign read_value_o = rd_q;

endmodule

// File: hdl/lpht_ctrl.sv
// Controller: request intake, probe sequencing and response valid.
module lpht_ctrl import lpht_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      req_valid_i,
  output logic      req_ready_o,
  output logic      rsp_valid_o,
  input  logic      rsp_ready_i,
  input  dp_stat_t  stat_i,
  output ctrl_cmd_t cmd_o
);

  typedef enum logic [1:0] {
    S_IDLE  = 2'b01,
    S_PROBE = 2'b10
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   out_free;

  assign out_free = !out_valid_q || rsp_ready_i;

  always_comb begin
    state_d      = state_q;
    cmd_o.load   = 1'b0;
    cmd_o.step   = 1'b0;
    cmd_o.commit = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        if (req_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_PROBE;
        end
      end
      S_PROBE: begin
        if (stat_i.done) begin
          // Hold on the final slot until the result register can be loaded.
          if (out_free) begin
            cmd_o.commit = 1'b1;
            state_d      = S_IDLE;
          end
        end else begin
          cmd_o.step = 1'b1;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  assign out_valid_d = cmd_o.commit || (out_valid_q && !rsp_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign req_ready_o = (state_q == S_IDLE);
  assign rsp_valid_o = out_valid_q;

endmodule

// File: hdl/linear_probe_hash_table_top.sv
// Top level of the linear-probing hash table: controller plus datapath.
//
// Usage: each transfer on the request channel carries one command (insert,
// lookup, update or delete) with a key and a value. Exactly one transfer on
// the response channel follows for every request, in order, carrying a
// status, the slot that was written or found, and the value read by a
// successful lookup.
// Timing: a request is taken, then the probe visits one slot per cycle,
// starting at the key's home slot (the low key bits). The search ends at
// the slot that settles it, or at the latest after a full lap of CAPACITY
// slots. The result register and the response valid flag are loaded together
// when the item commits.
// Requests are taken only between items. A finished response waits in an
// output register, so the next request is taken and probed while the
// receiver stalls; the probe holds on its final slot only if a second result
// is ready before the first has been taken.
// Reset marks every slot empty at once, returns the controller to idle and
// clears the response valid flag; the key and value stores are not cleared,
// since an entry is read only after write.
module linear_probe_hash_table_top import lpht_pkg::*; (
  input  logic   clk_i,
  input  logic   rst_ni,
  lpht_req_if.sink   req_i,
  lpht_rsp_if.source rsp_o
);

  ctrl_cmd_t ctrl_cmd;
  dp_stat_t  dp_stat;

  lpht_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_i.valid),
    .req_ready_o (req_i.ready),
    .rsp_valid_o (rsp_o.valid),
    .rsp_ready_i (rsp_o.ready),
    .stat_i      (dp_stat),
    .cmd_o       (ctrl_cmd)
  );

  lpht_dp u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (ctrl_cmd),
    .stat_o         (dp_stat),
    .command_i      (req_i.command),
    .record_key_i   (req_i.record_key),
    .record_value_i (req_i.record_value),
    .status_o       (rsp_o.status),
    .slot_index_o   (rsp_o.slot_index),
    .read_value_o   (rsp_o.read_value)
  );

endmodule

// File: tb/tb_top.sv
// Self-checking testbench for the linear-probing hash table top level.
module tb_top;
  import lpht_pkg::*;

  localparam int unsigned CLK_PERIOD     = 12;
  localparam int unsigned RANDOM_ITEMS   = 1720;
  localparam int unsigned POOL_SIZE      = 20;
  // Two items may be in flight: one parked in the output register, one probing.
  localparam int unsigned DRAIN_CYCLES   = 2 * (CAPACITY + 1) + 8;
  localparam int unsigned LIMIT_CYCLES   = 400_000;
  localparam int unsigned FIRST_HOLD_AT  = 700;
  localparam int unsigned FIRST_HOLD_LEN = 400;
  localparam int unsigned MAX_REPORTS    = 10;

  typedef logic [KEY_W-1:0]      key_t;
  typedef logic [DATA_W-1:0]     data_t;
  typedef logic [SLOT_OUT_W-1:0] slot_t;

  // One response transfer as the block should produce it.
  typedef struct packed {
    status_e status;
    slot_t   slot;
    data_t   rd;
  } table_rsp_t;

  // One row of the directed stimulus. Rows marked fixed carry a hand-written
  // response; the others are checked against the running table model.
  typedef struct {
    cmd_e       cmd;
    key_t       key;
    data_t      value;
    bit         fixed;
    table_rsp_t rsp;
  } stim_row_t;

  // Command mixes of the random episodes: grow the table, churn it, thin it.
  typedef enum logic [1:0] {MIX_FILL, MIX_CHURN, MIX_DRAIN} mix_e;
  // Behaviors of the response receiver.
  typedef enum logic [1:0] {RX_OPEN, RX_RANDOM, RX_PATTERN, RX_HOLD} rx_mode_e;

  logic clk_i = 1'b0;
  logic rst_n = 1'b0;

  lpht_req_if req ();
  lpht_rsp_if rsp ();

  linear_probe_hash_table_top uut (
    .clk_i  (clk_i),
    .rst_ni (rst_n),
    .req_i  (req),
    .rsp_o  (rsp)
  );

  // Shadow copy of the table, advanced once per accepted request.
  mark_e                 slot_state [CAPACITY];
  key_t                  slot_key   [CAPACITY];
  logic [VALUE_BITS-1:0] slot_value [CAPACITY];

  table_rsp_t  responses_due [$];
  stim_row_t   directed_rows [$];
  key_t        key_pool [POOL_SIZE];
  int unsigned mismatches = 0;
  int unsigned burst_left = 0;

  initial begin
    forever #(CLK_PERIOD / 2) clk_i = ~clk_i;
  end

  // Applies one command to the shadow table and returns the response it
  // earns. Inserts take the first slot that is empty or a tombstone; the
  // other commands stop at the first empty slot, step over tombstones and
  // give up after one full lap of the table.
  function automatic table_rsp_t probe_and_apply(cmd_e cmd, key_t key, data_t value);
    table_rsp_t  res;
    int unsigned idx;
    int unsigned n;
    int          hit;
    res.status = ST_DONE;
    res.slot   = '0;
    res.rd     = '0;
    idx = key % CAPACITY;
    hit = -1;
    for (n = 0; n < CAPACITY; n++) begin
      if (cmd == CMD_INSERT) begin
        if (slot_state[idx] != MARK_USED) begin
          hit = idx;
          break;
        end
      end else begin
        if (slot_state[idx] == MARK_EMPTY) break;
        if (slot_state[idx] == MARK_USED && slot_key[idx] == key) begin
          hit = idx;
          break;
        end
      end
      idx = (idx + 1) % CAPACITY;
    end
    if (hit < 0) begin
      res.status = (cmd == CMD_INSERT) ? ST_FULL : ST_NOT_FOUND;
    end else begin
      res.slot = slot_t'(hit);
      case (cmd)
        CMD_INSERT: begin
          slot_state[hit] = MARK_USED;
          slot_key[hit]   = key;
          slot_value[hit] = value[VALUE_BITS-1:0];
        end
        CMD_LOOKUP: res.rd = data_t'(slot_value[hit]);
        CMD_UPDATE: slot_value[hit] = value[VALUE_BITS-1:0];
        default:    slot_state[hit] = MARK_GRAVE;
      endcase
    end
    return res;
  endfunction

  function automatic void add_row(cmd_e cmd, key_t key, data_t value);
    stim_row_t row;
    row.cmd   = cmd;
    row.key   = key;
    row.value = value;
    row.fixed = 1'b0;
    row.rsp   = '0;
    directed_rows.push_back(row);
  endfunction

  function automatic void add_fixed(cmd_e cmd, key_t key, data_t value,
                                    status_e st, slot_t slot, data_t rd);
    stim_row_t row;
    row.cmd        = cmd;
    row.key        = key;
    row.value      = value;
    row.fixed      = 1'b1;
    row.rsp.status = st;
    row.rsp.slot   = slot;
    row.rsp.rd     = rd;
    directed_rows.push_back(row);
  endfunction

  // Keys are random, but half of them crowd onto four home slots so that
  // collisions, long probe chains and wrap-around are common.
  function automatic key_t fresh_key();
    key_t        k;
    int unsigned home;
    k = key_t'($urandom);
    if ($urandom_range(0, 1) == 0) home = $urandom_range(0, 3);
    else home = $urandom_range(0, CAPACITY - 1);
    k[SLOT_BITS-1:0] = home[SLOT_BITS-1:0];
    return k;
  endfunction

  // The sender works in bursts: at the end of a burst valid drops for a
  // random number of cycles before the next burst starts.
  task automatic pace_sender();
    if (burst_left == 0) begin
      req.valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk_i);
      burst_left = $urandom_range(1, 40);
    end
    burst_left--;
  endtask

  // Offers one request, waits for its transfer and records the response it
  // must produce. The model runs on every request so that it stays in step,
  // even where a fixed response is checked instead.
  task automatic issue(cmd_e cmd, key_t key, data_t value, bit fixed, table_rsp_t typed);
    table_rsp_t predicted;
    pace_sender();
    req.valid        <= 1'b1;
    req.command      <= cmd;
    req.record_key   <= key;
    req.record_value <= value;
    do @(posedge clk_i); while (req.ready !== 1'b1);
    predicted = probe_and_apply(cmd, key, value);
    responses_due.push_back(fixed ? typed : predicted);
  endtask

  initial begin : req_driver
    mix_e        mix;
    cmd_e        cmd;
    key_t        key;
    data_t       value;
    int unsigned episode_left;
    int unsigned r;
    int unsigned t_ins;
    int unsigned t_look;
    int unsigned t_upd;
    int unsigned n;

    req.valid        <= 1'b0;
    req.command      <= CMD_INSERT;
    req.record_key   <= '0;
    req.record_value <= '0;
    foreach (slot_state[i]) slot_state[i] = MARK_EMPTY;
    foreach (key_pool[i]) key_pool[i] = fresh_key();
    repeat (4) @(posedge clk_i);
    rst_n <= 1'b1;

    // On an empty table every search ends at once in a miss.
    add_fixed(CMD_LOOKUP, 31'd5, 32'h0, ST_NOT_FOUND, 4'd0, 32'h0);
    add_fixed(CMD_UPDATE, 31'd5, 32'hFFFF_FFFF, ST_NOT_FOUND, 4'd0, 32'h0);
    add_fixed(CMD_DELETE, 31'd5, 32'h0, ST_NOT_FOUND, 4'd0, 32'h0);
    // Largest key and value, then the smallest, each in its home slot.
    add_fixed(CMD_INSERT, 31'h7FFF_FFFF, 32'hFFFF_FFFF, ST_DONE, 4'd15, 32'h0);
    add_fixed(CMD_LOOKUP, 31'h7FFF_FFFF, 32'h0, ST_DONE, 4'd15, 32'hFFFF_FFFF);
    add_fixed(CMD_INSERT, 31'd0, 32'h0, ST_DONE, 4'd0, 32'h0);
    // Two more keys homed on the last slot wrap past slot 0.
    add_row(CMD_INSERT, 31'd15, 32'h1234_5678);
    add_row(CMD_INSERT, 31'd31, 32'h8765_4321);
    // A tombstone in the middle of the chain must not cut the search short,
    // and the next insert on that path reuses it.
    add_row(CMD_DELETE, 31'd15, 32'hDEAD_BEEF);
    add_row(CMD_LOOKUP, 31'd31, 32'h0);
    add_row(CMD_INSERT, 31'd47, 32'hA5A5_A5A5);
    // A duplicate key lands further along; searches find the first copy.
    add_row(CMD_INSERT, 31'd0, 32'hAAAA_5555);
    add_row(CMD_UPDATE, 31'd0, 32'h5555_AAAA);
    add_row(CMD_LOOKUP, 31'd0, 32'h0);
    // Fill every remaining slot.
    add_row(CMD_INSERT, 31'h4000_0004, 32'h0000_0001);
    add_row(CMD_INSERT, 31'h2AAA_AAA5, 32'h8000_0000);
    add_row(CMD_INSERT, 31'h5555_5556, 32'h5555_5555);
    add_row(CMD_INSERT, 31'h0000_0007, 32'hAAAA_AAAA);
    add_row(CMD_INSERT, 31'h7FFF_FFF8, 32'h0F0F_0F0F);
    add_row(CMD_INSERT, 31'h1234_5679, 32'hF0F0_F0F0);
    add_row(CMD_INSERT, 31'h6543_210A, 32'h00FF_00FF);
    add_row(CMD_INSERT, 31'h0F0F_0F0B, 32'hFF00_FF00);
    add_row(CMD_INSERT, 31'h70F0_F0FC, 32'h3333_CCCC);
    add_row(CMD_INSERT, 31'h3C3C_3C3D, 32'hCCCC_3333);
    add_row(CMD_INSERT, 31'h0000_000E, 32'h7FFF_FFFF);
    // With every slot taken an insert is refused and a miss walks a full lap.
    add_fixed(CMD_INSERT, 31'h1111_111F, 32'h1111_1111, ST_FULL, 4'd0, 32'h0);
    add_fixed(CMD_LOOKUP, 31'h1357_9BDF, 32'h0, ST_NOT_FOUND, 4'd0, 32'h0);

    foreach (directed_rows[i])
      issue(directed_rows[i].cmd, directed_rows[i].key, directed_rows[i].value,
            directed_rows[i].fixed, directed_rows[i].rsp);

    // Random episodes. Keys mostly come from a small pool, so lookups,
    // updates and deletes usually hit something that was inserted; a few
    // pool entries are replaced at the start of each episode.
    episode_left = 0;
    mix = MIX_CHURN;
    for (n = 0; n < RANDOM_ITEMS; n++) begin
      if (episode_left == 0) begin
        mix = mix_e'($urandom_range(0, 2));
        episode_left = $urandom_range(20, 80);
        repeat (3) key_pool[$urandom_range(0, POOL_SIZE - 1)] = fresh_key();
      end
      episode_left--;
      case (mix)
        MIX_FILL: begin
          t_ins = 60; t_look = 80; t_upd = 90;
        end
        MIX_DRAIN: begin
          t_ins = 10; t_look = 35; t_upd = 50;
        end
        default: begin
          t_ins = 25; t_look = 50; t_upd = 75;
        end
      endcase
      r = $urandom_range(0, 99);
      if (r < t_ins) cmd = CMD_INSERT;
      else if (r < t_look) cmd = CMD_LOOKUP;
      else if (r < t_upd) cmd = CMD_UPDATE;
      else cmd = CMD_DELETE;
      r = $urandom_range(0, 99);
      if (r < 85) key = key_pool[$urandom_range(0, POOL_SIZE - 1)];
      else if (r < 90) key = '0;
      else if (r < 95) key = '1;
      else key = key_t'($urandom);
      r = $urandom_range(0, 9);
      if (r == 0) value = '0;
      else if (r == 1) value = '1;
      else value = data_t'($urandom);
      issue(cmd, key, value, 1'b0, '0);
    end

    req.valid <= 1'b0;
    while (responses_due.size() != 0) @(posedge clk_i);
    // Anything the block still emits now has no request behind it.
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatches == 0 && responses_due.size() == 0)
      $display("PASS linear_probe_hash_table_top");
    else
      $display("FAIL linear_probe_hash_table_top");
    $finish;
  end

  // The receiver runs stretches of its own: always ready, random stalls, or a
  // rotating ready pattern, with the occasional long hold. One long hold is
  // forced early so that the output register and the probe both fill and the
  // request channel backs up while the sender keeps offering.
  initial begin : rx_pacing
    rx_mode_e    mode;
    int unsigned span;
    int unsigned stall_pct;
    int unsigned cycles;
    int unsigned r;
    int unsigned i;
    logic [7:0]  pattern;
    bit          held;
    rsp.ready <= 1'b0;
    cycles    = 0;
    held      = 1'b0;
    stall_pct = 0;
    pattern   = 8'b1011_0010;
    wait (rst_n === 1'b1);
    forever begin
      if (!held && cycles >= FIRST_HOLD_AT) begin
        mode = RX_HOLD;
        span = FIRST_HOLD_LEN;
        held = 1'b1;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 30) mode = RX_OPEN;
        else if (r < 65) mode = RX_RANDOM;
        else if (r < 95) mode = RX_PATTERN;
        else mode = RX_HOLD;
        span      = (mode == RX_HOLD) ? $urandom_range(40, 250) : $urandom_range(10, 120);
        stall_pct = $urandom_range(10, 80);
        pattern   = 8'($urandom) | 8'h01;
      end
      for (i = 0; i < span; i++) begin
        case (mode)
          RX_OPEN:    rsp.ready <= 1'b1;
          RX_RANDOM:  rsp.ready <= ($urandom_range(0, 99) >= stall_pct);
          RX_PATTERN: begin
            rsp.ready <= pattern[0];
            pattern = {pattern[0], pattern[7:1]};
          end
          default:    rsp.ready <= 1'b0;
        endcase
        @(posedge clk_i);
        cycles++;
      end
    end
  end

  task automatic note_failure(string msg);
    mismatches++;
    if (mismatches <= MAX_REPORTS) $display("%s", msg);
  endtask

  // Every response transfer is matched in order against the oldest response due.
  always @(posedge clk_i) begin : rsp_check
    table_rsp_t want;
    if (rsp.valid === 1'b1 && rsp.ready === 1'b1) begin
      if (responses_due.size() == 0) begin
        note_failure($sformatf("%0t: response with no request due: status %0d slot %0d value %h",
                               $time, rsp.status, rsp.slot_index, rsp.read_value));
      end else begin
        want = responses_due.pop_front();
        if (rsp.status !== want.status || rsp.slot_index !== want.slot ||
            rsp.read_value !== want.rd)
          note_failure($sformatf({"%0t: response mismatch: expected status %0d slot %0d ",
                                  "value %h, got status %0d slot %0d value %h"},
                                 $time, want.status, want.slot, want.rd,
                                 rsp.status, rsp.slot_index, rsp.read_value));
      end
    end
  end

  initial begin : run_limit
    #(LIMIT_CYCLES * CLK_PERIOD);
    $display("FAIL linear_probe_hash_table_top");
    $finish;
  end

endmodule
